@@ rtl/bs_pkg.sv @@
// Shared constants, payload types and the microcode program of the bitonic sorter.
`timescale 1ns / 1ps
`default_nettype none

package bs_pkg;

    localparam int SET_SIZE = 64;
    localparam int LOG_N    = $clog2(SET_SIZE);
    localparam int ADDR_W   = LOG_N;
    localparam int CNT_W    = $clog2(SET_SIZE + 1);
    localparam int LG_W     = $clog2(LOG_N + 1);
    localparam int PAIR_W   = (LOG_N > 1) ? LOG_N - 1 : 1;
    localparam int DATA_W   = 32;
    localparam int UPC_W    = 4;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     last_in;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] sorted_value;
        logic                     last_out;
        logic                     overflow;
    } t_out_item;

    typedef logic [UPC_W-1:0] t_upc;

    typedef enum logic [3:0] {
        OP_LOAD,
        OP_PAD,
        OP_INIT,
        OP_READ,
        OP_CMP,
        OP_WR2,
        OP_ADVRD,
        OP_EMIT,
        OP_DONE
    } t_op;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NOT_LAST_ACC,
        C_NOT_FULL,
        C_NO_SWAP,
        C_MORE,
        C_EMIT_MORE
    } t_cond;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_upc  target;
    } t_uword;

    typedef struct packed {
        t_op  op;
        logic accept;
    } t_ctrl;

    typedef struct packed {
        logic last_acc;
        logic full;
        logic swap;
        logic more;
        logic emit_more;
    } t_status;

    localparam t_upc UA_LOAD  = t_upc'(0);
    localparam t_upc UA_PAD   = t_upc'(1);
    localparam t_upc UA_INIT  = t_upc'(2);
    localparam t_upc UA_READ  = t_upc'(3);
    localparam t_upc UA_CMP   = t_upc'(4);
    localparam t_upc UA_WR2   = t_upc'(5);
    localparam t_upc UA_ADVRD = t_upc'(6);
    localparam t_upc UA_EMIT  = t_upc'(7);
    localparam t_upc UA_DONE  = t_upc'(8);

    // Each word jumps to its target when the condition holds, else falls through.
    function automatic t_uword ucode_rom(input t_upc pc);
        t_uword w;
        unique case (pc)
            UA_LOAD:  w = '{op: OP_LOAD,  cond: C_NOT_LAST_ACC, target: UA_LOAD};
            UA_PAD:   w = '{op: OP_PAD,   cond: C_NOT_FULL,     target: UA_PAD};
            UA_INIT:  w = '{op: OP_INIT,  cond: C_NEVER,        target: UA_LOAD};
            UA_READ:  w = '{op: OP_READ,  cond: C_NEVER,        target: UA_LOAD};
            UA_CMP:   w = '{op: OP_CMP,   cond: C_NO_SWAP,      target: UA_ADVRD};
            UA_WR2:   w = '{op: OP_WR2,   cond: C_NEVER,        target: UA_LOAD};
            UA_ADVRD: w = '{op: OP_ADVRD, cond: C_MORE,         target: UA_CMP};
            UA_EMIT:  w = '{op: OP_EMIT,  cond: C_EMIT_MORE,    target: UA_EMIT};
            UA_DONE:  w = '{op: OP_DONE,  cond: C_ALWAYS,       target: UA_LOAD};
            default:  w = '{op: OP_DONE,  cond: C_ALWAYS,       target: UA_LOAD};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

@@ rtl/bs_ram.sv @@
// Generic single-write, dual-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module bs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic      [WIDTH-1:0]         o_rdata_a,
    output logic      [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

`default_nettype wire

@@ rtl/bs_useq.sv @@
// Microcode sequencer: program counter, control store and jump condition select.
`timescale 1ns / 1ps
`default_nettype none

module bs_useq (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            start,
    input  wire bs_pkg::t_status i_status,
    output bs_pkg::t_ctrl        o_ctrl,
    output logic                 busy
);
    import bs_pkg::*;

    t_upc   r_pc;
    t_upc   n_pc;
    t_uword uword;
    logic   take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= UA_LOAD;
        end else begin
            r_pc <= n_pc;
        end
    end

    always_comb begin
        uword = ucode_rom(r_pc);
        busy  = (r_pc != UA_LOAD);
        unique case (uword.cond)
            C_NEVER:        take = 1'b0;
            C_ALWAYS:       take = 1'b1;
            C_NOT_LAST_ACC: take = !i_status.last_acc;
            C_NOT_FULL:     take = !i_status.full;
            C_NO_SWAP:      take = !i_status.swap;
            C_MORE:         take = i_status.more;
            C_EMIT_MORE:    take = i_status.emit_more;
            default:        take = 1'b0;
        endcase
        n_pc          = take ? uword.target : t_upc'(r_pc + t_upc'(1));
        o_ctrl.op     = uword.op;
        o_ctrl.accept = start && !busy;
    end

endmodule

`default_nettype wire

@@ rtl/bs_datapath.sv @@
// Datapath: element store, loop counters, compare-exchange unit and result register.
`timescale 1ns / 1ps
`default_nettype none

module bs_datapath (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire bs_pkg::t_ctrl    i_ctrl,
    input  wire bs_pkg::t_in_item i_item,
    input  wire logic             i_cfg_wr,
    input  wire logic             i_cfg_data,
    output bs_pkg::t_status       o_status,
    output logic                  o_valid,
    output bs_pkg::t_out_item     o_result
);
    import bs_pkg::*;

    // Lower address of a pair: the pair index with a zero inserted at the gap bit.
    function automatic logic [ADDR_W-1:0] lo_addr(input logic [PAIR_W-1:0] p,
                                                  input logic [LG_W-1:0]   g);
        logic [ADDR_W-1:0] a;
        a = '0;
        for (int b = 0; b < ADDR_W; b++) begin
            if (b < PAIR_W && LG_W'(b) < g) begin
                a[b] = p[b];
            end else if (b > 0 && LG_W'(b) > g) begin
                a[b] = p[b-1];
            end
        end
        return a;
    endfunction

    function automatic logic [ADDR_W-1:0] hi_addr(input logic [ADDR_W-1:0] lo,
                                                  input logic [LG_W-1:0]   g);
        logic [ADDR_W-1:0] a;
        a = lo;
        for (int b = 0; b < ADDR_W; b++) begin
            if (LG_W'(b) == g) begin
                a[b] = 1'b1;
            end
        end
        return a;
    endfunction

    logic [CNT_W-1:0]  r_cnt,   n_cnt;
    logic              r_ovf,   n_ovf;
    logic              r_asc;
    logic [LG_W-1:0]   r_sz,    n_sz;
    logic [LG_W-1:0]   r_gap,   n_gap;
    logic [PAIR_W-1:0] r_pair,  n_pair;
    logic [ADDR_W-1:0] r_ecnt,  n_ecnt;
    logic [DATA_W-1:0] r_hold,  n_hold;
    logic              r_rvld,  n_rvld;
    logic              r_rlast, n_rlast;

    logic [LG_W-1:0]   adv_sz, adv_gap;
    logic [PAIR_W-1:0] adv_pair;
    logic              pair_last, sort_done, full, dir_bit, up, swap;
    logic [ADDR_W-1:0] cur_lo, cur_hi, adv_lo, adv_hi;

    logic              we;
    logic [ADDR_W-1:0] waddr, raddr_a, raddr_b;
    logic [DATA_W-1:0] wdata, qa, qb;

    bs_ram #(
        .WIDTH (DATA_W),
        .DEPTH (SET_SIZE)
    ) u_store (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_waddr   (waddr),
        .i_wdata   (wdata),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (qa),
        .o_rdata_b (qb)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_ovf   <= 1'b0;
            r_asc   <= 1'b1;
            r_sz    <= '0;
            r_gap   <= '0;
            r_pair  <= '0;
            r_ecnt  <= '0;
            r_rvld  <= 1'b0;
            r_rlast <= 1'b0;
        end else begin
            r_cnt   <= n_cnt;
            r_ovf   <= n_ovf;
            r_sz    <= n_sz;
            r_gap   <= n_gap;
            r_pair  <= n_pair;
            r_ecnt  <= n_ecnt;
            r_rvld  <= n_rvld;
            r_rlast <= n_rlast;
            if (i_cfg_wr) begin
                r_asc <= i_cfg_data;
            end
        end
        r_hold <= n_hold;
    end

    // Pair and stage stepping.
    always_comb begin
        full      = (r_cnt == CNT_W'(SET_SIZE));
        pair_last = (r_pair == PAIR_W'(SET_SIZE / 2 - 1));
        sort_done = pair_last && (r_gap == '0) && (r_sz == LG_W'(LOG_N));
        adv_pair  = pair_last ? '0 : PAIR_W'(r_pair + PAIR_W'(1));
        adv_sz    = r_sz;
        adv_gap   = r_gap;
        if (pair_last) begin
            if (r_gap == '0) begin
                if (r_sz != LG_W'(LOG_N)) begin
                    adv_sz  = LG_W'(r_sz + LG_W'(1));
                    adv_gap = r_sz;
                end
            end else begin
                adv_gap = LG_W'(r_gap - LG_W'(1));
            end
        end
        cur_lo = lo_addr(r_pair, r_gap);
        cur_hi = hi_addr(cur_lo, r_gap);
        adv_lo = lo_addr(adv_pair, adv_gap);
        adv_hi = hi_addr(adv_lo, adv_gap);

        // The block-size bit of the lower address picks the direction of this pair.
        dir_bit = 1'b0;
        for (int b = 0; b < ADDR_W; b++) begin
            if (LG_W'(b) == r_sz) begin
                dir_bit = cur_lo[b];
            end
        end
        up   = (!dir_bit) == r_asc;
        swap = up ? ($signed(qa) > $signed(qb)) : ($signed(qb) > $signed(qa));
    end

    always_comb begin
        n_cnt   = r_cnt;
        n_ovf   = r_ovf;
        n_sz    = r_sz;
        n_gap   = r_gap;
        n_pair  = r_pair;
        n_ecnt  = r_ecnt;
        n_hold  = r_hold;
        n_rvld  = 1'b0;
        n_rlast = 1'b0;
        we      = 1'b0;
        waddr   = r_cnt[ADDR_W-1:0];
        wdata   = '0;
        raddr_a = cur_lo;
        raddr_b = cur_hi;
        unique case (i_ctrl.op)
            OP_LOAD: begin
                if (i_ctrl.accept) begin
                    if (!full) begin
                        we    = 1'b1;
                        wdata = i_item.value;
                        n_cnt = CNT_W'(r_cnt + CNT_W'(1));
                    end else begin
                        n_ovf = 1'b1;
                    end
                end
            end
            OP_PAD: begin
                if (!full) begin
                    we    = 1'b1;
                    n_cnt = CNT_W'(r_cnt + CNT_W'(1));
                end
            end
            OP_INIT: begin
                n_sz   = LG_W'(1);
                n_gap  = '0;
                n_pair = '0;
                n_ecnt = '0;
            end
            OP_READ: begin
            end
            OP_CMP: begin
                n_hold = qa;
                we     = swap;
                waddr  = cur_lo;
                wdata  = qb;
            end
            OP_WR2: begin
                we    = 1'b1;
                waddr = cur_hi;
                wdata = r_hold;
            end
            OP_ADVRD: begin
                n_sz    = adv_sz;
                n_gap   = adv_gap;
                n_pair  = adv_pair;
                raddr_a = adv_lo;
                raddr_b = adv_hi;
            end
            OP_EMIT: begin
                raddr_a = r_ecnt;
                n_ecnt  = ADDR_W'(r_ecnt + ADDR_W'(1));
                n_rvld  = 1'b1;
                n_rlast = (r_ecnt == ADDR_W'(SET_SIZE - 1));
            end
            OP_DONE: begin
                n_cnt = '0;
                n_ovf = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_status.last_acc  = i_ctrl.accept && i_item.last_in;
        o_status.full      = full;
        o_status.swap      = swap;
        o_status.more      = !sort_done;
        o_status.emit_more = (r_ecnt != ADDR_W'(SET_SIZE - 1));
        o_valid                = r_rvld;
        o_result.sorted_value  = qa;
        o_result.last_out      = r_rlast;
        o_result.overflow      = r_ovf;
    end

endmodule

`default_nettype wire

@@ rtl/bitonic_sorter_core.sv @@
// Top level of the bitonic sorter: sequencer and datapath.
//
// Usage. Elements are offered one per transfer on the command channel: an
// element is taken at a rising edge with start high and busy low. The element
// with last_in set closes the set and starts the sort. Up to SET_SIZE elements
// are kept; further ones are dropped and flag overflow on every result of that
// set. Slots that were not loaded are filled with zero before sorting.
// After the closing element the block pads the unloaded slots, runs the setup
// steps INIT and READ, performs SET_SIZE/2 * log2(N) * (log2(N) + 1) / 2
// compare-exchanges, each a CMP and an ADVRD step with a WR2 step between them
// only when the pair swaps, since the store has one write port, and then emits
// the set. At 64 elements the sort is 672 compare-exchanges. Results leave on
// o_valid, one per cycle in sorted order, with last_out on the final one; the
// receiver cannot stall them. busy drops in the cycle after the last result,
// so a new set may start right away.
// The direction register is written through the cfg channel, which is always
// ready; it holds 1 (ascending) after reset. Reset returns the sequencer to the
// load step and empties the set; the store needs no clearing pass because
// padding overwrites every unloaded slot.

`timescale 1ns / 1ps
`default_nettype none

module bitonic_sorter_core (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire bs_pkg::t_in_item i_item,
    output logic                  o_valid,
    output bs_pkg::t_out_item     o_result,
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic             i_cfg_data
);
    import bs_pkg::*;

    t_ctrl   ctrl;
    t_status status;

    // The direction register can take a transfer in any cycle.
    assign o_cfg_ready = 1'b1;

    bs_useq u_useq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_status (status),
        .o_ctrl   (ctrl),
        .busy     (busy)
    );

    bs_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (ctrl),
        .i_item     (i_item),
        .i_cfg_wr   (i_cfg_valid && o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .o_status   (status),
        .o_valid    (o_valid),
        .o_result   (o_result)
    );

endmodule

`default_nettype wire

@@ rtl/bs_checker.sv @@
// Port-level checker for the bitonic sorter and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none

module bs_checker (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              start,
    input wire logic              busy,
    input wire logic              o_valid,
    input wire bs_pkg::t_out_item o_result,
    input wire bs_pkg::t_in_item  i_item
);
    import bs_pkg::*;

    // Results only appear while the block is working on a set.
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy)
        else $error("result strobe while not busy");

    a_last_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.last_out |-> o_valid)
        else $error("last_out without strobe");

    // Results of a set come out back to back.
    a_emit_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_result.last_out) |=> o_valid)
        else $error("gap in result stream");

    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.last_out) |=> !busy)
        else $error("still busy after final result");

    a_close_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_item.last_in) |=> busy)
        else $error("closing transfer did not start the sort");

endmodule

bind bitonic_sorter_core bs_checker u_bs_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_valid  (o_valid),
    .o_result (o_result),
    .i_item   (i_item)
);

`default_nettype wire
